FILE: sv/gbn_pkg.sv
// Shared types, codes and helpers for the go-back-n sender window block.
// No dependencies; every other file but gbn_checker refers to it by scoped names.
package gbn_pkg;

	localparam int WINDOW_DEF        = 32;
	localparam int PAYLOAD_BYTES_DEF = 1024;

	localparam int SEQ_W   = 16;
	localparam int BYTES_W = 11;
	localparam int ACT_W   = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [ACT_W-1:0] ACT_START   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ACK     = 2'd1;
	localparam logic [ACT_W-1:0] ACT_TIMEOUT = 2'd2;

	localparam logic [SEQ_W-1:0] ABORT_ACK = 16'hFFFF;

	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PACKETS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_BYTES    = 1'd1;

	localparam logic [SEQ_W-1:0]   TOTAL_RESET      = 16'd1;
	localparam logic [BYTES_W-1:0] LAST_BYTES_RESET = 11'd1024;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_EMIT
	} gbn_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic evaluate;
		logic advance;
	} gbn_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic last_item;
	} gbn_sts_t;

	// Grow the window up to the window size or the end of the transfer.
	function automatic logic [SEQ_W-1:0] refill(input logic [SEQ_W-1:0] base,
		input logic [SEQ_W-1:0] nxt, input logic [SEQ_W-1:0] total,
		input logic [SEQ_W:0] window);
		logic [SEQ_W:0]   lim;
		logic [SEQ_W-1:0] r;
		lim = {1'b0, base} + window;
		r   = nxt;
		if ((nxt < total) && ({1'b0, nxt} < lim)) begin
			if (lim < {1'b0, total}) begin
				r = lim[SEQ_W-1:0];
			end else begin
				r = total;
			end
		end
		return r;
	endfunction

endpackage

FILE: sv/gbn_if.sv
// Valid/ready channel interfaces for event requests, send results and
// configuration writes. Depends on gbn_pkg for field widths.
interface gbn_in_if;
	logic                        valid;
	logic                        ready;
	logic [gbn_pkg::ACT_W-1:0]   action;
	logic [gbn_pkg::SEQ_W-1:0]   ack_number;
	modport source(output valid, output action, output ack_number, input ready);
	modport sink(input valid, input action, input ack_number, output ready);
endinterface

interface gbn_out_if;
	logic                        valid;
	logic                        ready;
	logic                        send_valid;
	logic [gbn_pkg::SEQ_W-1:0]   send_seq;
	logic [gbn_pkg::BYTES_W-1:0] payload_bytes;
	logic                        last;
	logic                        done_res;
	modport source(output valid, output send_valid, output send_seq,
		output payload_bytes, output last, output done_res, input ready);
	modport sink(input valid, input send_valid, input send_seq,
		input payload_bytes, input last, input done_res, output ready);
endinterface

interface gbn_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [gbn_pkg::CFG_IDX_W-1:0]  index;
	logic [gbn_pkg::CFG_DATA_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

FILE: sv/gbn_ctrl.sv
// Controller state machine for the go-back-n sender window.
// Depends on gbn_pkg for the state enum and command/status structs.
module gbn_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  gbn_pkg::gbn_sts_t sts,
	output gbn_pkg::gbn_cmd_t cmd
);

	gbn_pkg::gbn_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbn_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gbn_pkg::ST_IDLE: begin
				if (in_valid) state_d = gbn_pkg::ST_EVAL;
			end
			gbn_pkg::ST_EVAL: begin
				state_d = gbn_pkg::ST_EMIT;
			end
			gbn_pkg::ST_EMIT: begin
				if (out_ready && sts.last_item) state_d = gbn_pkg::ST_IDLE;
			end
			default: begin
				state_d = gbn_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		out_valid    = 1'b0;
		cmd          = '0;
		case (state_q)
			gbn_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			gbn_pkg::ST_EVAL: begin
				cmd.evaluate = 1'b1;
			end
			gbn_pkg::ST_EMIT: begin
				out_valid   = 1'b1;
				cmd.advance = out_ready && !sts.last_item;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

FILE: sv/gbn_dp.sv
// Datapath: configuration, window state, event evaluation and send cursor.
// Depends on gbn_pkg for widths, codes, structs and the refill helper.
module gbn_dp #(
	parameter int WINDOW        = gbn_pkg::WINDOW_DEF,
	parameter int PAYLOAD_BYTES = gbn_pkg::PAYLOAD_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  gbn_pkg::gbn_cmd_t              cmd,
	output gbn_pkg::gbn_sts_t              sts,
	input  logic [gbn_pkg::ACT_W-1:0]      action,
	input  logic [gbn_pkg::SEQ_W-1:0]      ack_number,
	input  logic                           cfg_we,
	input  logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           send_valid,
	output logic [gbn_pkg::SEQ_W-1:0]      send_seq,
	output logic [gbn_pkg::BYTES_W-1:0]    payload_bytes,
	output logic                           last,
	output logic                           done_res
);

	localparam logic [gbn_pkg::SEQ_W:0]     WIN_SIZE   = (gbn_pkg::SEQ_W+1)'(WINDOW);
	localparam logic [gbn_pkg::BYTES_W-1:0] FULL_BYTES = gbn_pkg::BYTES_W'(PAYLOAD_BYTES);

	logic [gbn_pkg::SEQ_W-1:0]   total_q;
	logic [gbn_pkg::BYTES_W-1:0] last_bytes_q;
	logic [gbn_pkg::SEQ_W-1:0]   base_q, next_q, last_ack_q;
	logic                        fin_q;
	logic [gbn_pkg::ACT_W-1:0]   action_q;
	logic [gbn_pkg::SEQ_W-1:0]   ack_q;
	logic [gbn_pkg::SEQ_W-1:0]   cur_q, end_q;
	logic                        empty_q;

	// Evaluation results
	logic [gbn_pkg::SEQ_W-1:0] base_d, next_d, last_ack_d, from_d, to_d;
	logic                      fin_d;
	logic [gbn_pkg::SEQ_W-1:0] refill_base, refill_next;
	logic [gbn_pkg::SEQ_W:0]   ack_inc;
	logic [gbn_pkg::SEQ_W-1:0] final_seq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q      <= gbn_pkg::TOTAL_RESET;
			last_bytes_q <= gbn_pkg::LAST_BYTES_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				gbn_pkg::CFG_TOTAL_PACKETS: total_q      <= cfg_data;
				gbn_pkg::CFG_LAST_BYTES:    last_bytes_q <= cfg_data[gbn_pkg::BYTES_W-1:0];
				default:                    total_q      <= total_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= action;
			ack_q    <= ack_number;
		end
	end

	assign ack_inc     = {1'b0, ack_q} + 17'd1;
	assign refill_next = gbn_pkg::refill(refill_base, next_q, total_q, WIN_SIZE);

	// Slide the base past an accepted ack when it lies between the last ack and
	// this one; never past next_seq.
	always_comb begin
		refill_base = base_q;
		if (!fin_q && (action_q == gbn_pkg::ACT_ACK) && (ack_q != gbn_pkg::ABORT_ACK)
			&& (ack_q >= last_ack_q) && (base_q inside {[last_ack_q:ack_q]})) begin
			refill_base = (ack_inc < {1'b0, next_q}) ?
				ack_inc[gbn_pkg::SEQ_W-1:0] : next_q;
		end
	end

	always_comb begin
		base_d      = base_q;
		next_d      = next_q;
		last_ack_d  = last_ack_q;
		fin_d       = fin_q;
		from_d      = '0;
		to_d        = '0;
		if (!fin_q) begin
			case (action_q)
				gbn_pkg::ACT_START: begin
					next_d = refill_next;
					from_d = base_q;
					to_d   = refill_next;
				end
				gbn_pkg::ACT_ACK: begin
					if (ack_q == gbn_pkg::ABORT_ACK) begin
						fin_d = 1'b1;
					end else if (ack_q >= last_ack_q) begin
						base_d     = refill_base;
						last_ack_d = ack_q;
						next_d     = refill_next;
						from_d     = next_q;
						to_d       = refill_next;
						if (ack_q == final_seq) fin_d = 1'b1;
					end
				end
				gbn_pkg::ACT_TIMEOUT: begin
					from_d = base_q;
					to_d   = next_q;
				end
				default: begin
					fin_d = fin_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= '0;
			next_q     <= '0;
			last_ack_q <= '0;
			fin_q      <= 1'b0;
		end else if (cmd.evaluate) begin
			base_q     <= base_d;
			next_q     <= next_d;
			last_ack_q <= last_ack_d;
			fin_q      <= fin_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.evaluate) begin
			cur_q   <= from_d;
			end_q   <= to_d;
			empty_q <= (from_d == to_d);
		end else if (cmd.advance) begin
			cur_q <= cur_q + 16'd1;
		end
	end

	assign final_seq     = total_q - 16'd1;
	assign sts.last_item = empty_q || (({1'b0, cur_q} + 17'd1) == {1'b0, end_q});
	assign send_valid    = !empty_q;
	assign send_seq      = empty_q ? '0 : cur_q;
	assign payload_bytes = empty_q ? '0 : ((cur_q == final_seq) ? last_bytes_q : FULL_BYTES);
	assign last          = sts.last_item;
	assign done_res      = fin_q;

endmodule

FILE: sv/go_back_n_sender_window_top.sv
// Go-back-n sender window: top level joining controller and datapath.
// Depends on gbn_pkg, gbn_if, gbn_ctrl and gbn_dp.
//
// Each event request (start, ack, timeout) is taken when the block is idle and
// answered by a run of send results, one per cycle while the sink is ready;
// the last result of the run carries last. A run holds k results (1 up to
// WINDOW). The controller first captures the request, then updates the
// window state, then the send cursor steps through the sequence numbers to
// transmit. An event that sends nothing yields one result with send_valid low.
// done_res shows the finished flag after the event. Configuration writes are
// always accepted and take effect once registered, also during a run.
module go_back_n_sender_window_top #(
	parameter int WINDOW        = gbn_pkg::WINDOW_DEF,
	parameter int PAYLOAD_BYTES = gbn_pkg::PAYLOAD_BYTES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	gbn_in_if.sink     in_ch,
	gbn_out_if.source  out_ch,
	gbn_cfg_if.sink    cfg
);

	gbn_pkg::gbn_cmd_t cmd;
	gbn_pkg::gbn_sts_t sts;

	// Registers are plain flops: take every write request at once.
	assign cfg.ready = 1'b1;

	gbn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Hold window state, evaluate the captured request, advance the cursor.
	gbn_dp #(
		.WINDOW        (WINDOW),
		.PAYLOAD_BYTES (PAYLOAD_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.action        (in_ch.action),
		.ack_number    (in_ch.ack_number),
		.cfg_we        (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.send_valid    (out_ch.send_valid),
		.send_seq      (out_ch.send_seq),
		.payload_bytes (out_ch.payload_bytes),
		.last          (out_ch.last),
		.done_res      (out_ch.done_res)
	);

endmodule

FILE: sv/gbn_checker.sv
// Port-level checks for the go-back-n sender window, bound to the top level.
// Depends on go_back_n_sender_window_top and its channel interfaces.
module gbn_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic send_valid,
	input logic last
);

	// One request at a time: never take a request while a run is shown.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("request taken while results pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready stayed high after a request");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=> out_valid)
		else $error("run ended without last");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !send_valid) |-> last)
		else $error("empty result not marked last");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last) |=> in_ready)
		else $error("not ready after final result");

endmodule

bind go_back_n_sender_window_top gbn_checker u_gbn_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.send_valid (out_ch.send_valid),
	.last       (out_ch.last)
);
